// File: src/crs_pkg.sv
// Shared types and constants for the Catmull-Rom spline sampler.
// No dependencies; every other file imports this package.
package crs_pkg;

   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = 8;
   localparam int COORD_W    = 32;
   localparam int T_W        = 16;
   localparam int H_W        = 39;
   localparam int P_W        = H_W + T_W + 1;
   localparam int POS_W      = 3 * COORD_W;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = 2;

   localparam logic [1:0] CSR_CLOSED = 2'd0;
   localparam logic [1:0] CSR_SPS    = 2'd1;
   localparam logic [1:0] CSR_COUNT  = 2'd2;

   typedef struct packed {
      logic                       closed;
      logic [7:0]                 sps;
      logic [8:0]                 count;
   } crs_cfg_type;

   typedef struct packed {
      logic                       is_write;
      logic                       bad;
      logic                       endpt;
      logic [3:0][IDX_W-1:0]      idx;
      logic [T_W-1:0]             t;
      logic [POS_W-1:0]           pos;
   } crs_job_type;

endpackage

// File: src/catmull_rom_spline_sampler.sv
// Catmull-Rom spline sampler: a write is accepted and pushed by the front end and popped into
// the point table by the back end, with no result. Evaluate: the front end accepts, runs the t
// divider (two quotient bits per cycle) and pushes; the back end pops, does the table reads, a
// coefficient step and 3 multiply/add pairs, then registers the result. Synchronous active-high
// reset clears control state and loads closed_loop=0, samples_per_segment=8, point_count=4;
// the point table is not cleared. The back end finishes one evaluation before popping the next.
module catmull_rom_spline_sampler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // slot[7:0], sample_number[14:8], pos_x, pos_y, pos_z
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // curve_x[31:0], curve_y, curve_z
   output logic         rsp_tuser,   // bad_request
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [8:0]   csr_wdata
);
   import crs_pkg::*;

   crs_cfg_type cfg_ff;
   logic        push, full, pop, empty;
   crs_job_type push_job, head;

   // config registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.closed <= 1'b0;
         cfg_ff.sps    <= 8'd8;
         cfg_ff.count  <= 9'd4;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CLOSED: cfg_ff.closed <= csr_wdata[0];
            CSR_SPS:    cfg_ff.sps    <= csr_wdata[7:0];
            CSR_COUNT:  cfg_ff.count  <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // classify each transaction and compute indices and t
   crs_front u_front (
      .clock, .reset, .cfg(cfg_ff),
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .push, .job(push_job), .full
   );

   // hold jobs so the two halves stall independently
   crs_queue u_queue (
      .clock, .reset, .push, .push_job, .full, .pop, .head, .empty
   );

   // table writes, reads, cubic evaluation and result register
   crs_back u_back (
      .clock, .reset, .head, .empty, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

endmodule

// File: src/crs_front.sv
// Front end: accepts request transactions, classifies them, works out
// neighbor indices and the spline parameter t. Depends on crs_pkg.
module crs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  crs_pkg::crs_cfg_type cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [111:0]         req_tdata,
   input  logic                 req_tuser,
   output logic                 push,
   output crs_pkg::crs_job_type job,
   input  logic                 full
);
   import crs_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [7:0]      rem_ff, rem_in;
   logic [7:0]      sps_ff, sps_in;
   crs_job_type     job_ff, job_in;

   logic [8:0]      count_eff, last, segs;
   logic [7:0]      sps_eff, slot;
   logic [6:0]      sample;
   logic [9:0]      s1, s2;
   logic            endpt, bad;
   logic [8:0]      r2a, r2b;
   logic [7:0]      ra;
   logic            qa, qb;

   assign slot   = req_tdata[7:0];
   assign sample = req_tdata[14:8];

   always_comb begin
      count_eff = cfg.count;
      if (cfg.count < 9'd2) count_eff = 9'd2;
      if (cfg.count > 9'(MAX_POINTS)) count_eff = 9'(MAX_POINTS);
      sps_eff = cfg.sps;
      if (cfg.sps == 8'd0) sps_eff = 8'd1;
      if (cfg.sps > 8'd128) sps_eff = 8'd128;
      last  = count_eff - 9'd1;
      segs  = cfg.closed ? count_eff : last;
      endpt = !cfg.closed && ({1'b0, slot} == last) && (sample == 7'd0);
      bad   = !endpt && (({1'b0, slot} >= segs) || ({1'b0, sample} >= sps_eff));
      s1    = {2'b00, slot} + 10'd1;
      s2    = {2'b00, slot} + 10'd2;
   end

   // two restoring division steps per cycle
   always_comb begin
      r2a = {rem_ff, 1'b0};
      qa  = r2a >= {1'b0, sps_ff};
      ra  = qa ? 8'(r2a - {1'b0, sps_ff}) : r2a[7:0];
      r2b = {ra, 1'b0};
      qb  = r2b >= {1'b0, sps_ff};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      sps_in   = sps_ff;
      job_in   = job_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               job_in.is_write = !req_tuser;
               job_in.pos      = req_tdata[110:15];
               job_in.endpt    = endpt;
               job_in.bad      = bad;
               job_in.t        = '0;
               if (!req_tuser) begin
                  job_in.idx    = {4{slot}};
                  job_in.bad    = 1'b0;
                  job_in.endpt  = 1'b0;
               end else if (endpt) begin
                  job_in.idx    = {4{last[7:0]}};
               end else if (cfg.closed) begin
                  job_in.idx[0] = (slot == 8'd0) ? last[7:0] : slot - 8'd1;
                  job_in.idx[1] = slot;
                  job_in.idx[2] = (s1 >= {1'b0, count_eff}) ? 8'(s1 - {1'b0, count_eff})
                                                            : s1[7:0];
                  job_in.idx[3] = (s2 >= {1'b0, count_eff}) ? 8'(s2 - {1'b0, count_eff})
                                                            : s2[7:0];
               end else begin
                  job_in.idx[0] = (slot == 8'd0) ? 8'd0 : slot - 8'd1;
                  job_in.idx[1] = slot;
                  job_in.idx[2] = s1[7:0];
                  job_in.idx[3] = (s2 > {1'b0, last}) ? last[7:0] : s2[7:0];
               end
               rem_in = {1'b0, sample};
               sps_in = sps_eff;
               cnt_in = '0;
               state_in = (req_tuser && !bad && !endpt) ? F_DIV : F_PUSH;
            end
         end
         F_DIV: begin
            rem_in   = qb ? 8'(r2b - {1'b0, sps_ff}) : r2b[7:0];
            job_in.t = {job_ff.t[T_W-3:0], qa, qb};
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff <= rem_in;
      sps_ff <= sps_in;
      job_ff <= job_in;
   end

   assign req_tready = (state_ff == F_IDLE);
   assign push       = (state_ff == F_PUSH) && !full;
   assign job        = job_ff;

endmodule

// File: src/crs_queue.sv
// Short job queue between the front and back ends.
// Depends on crs_pkg for the job type and depth.
module crs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  crs_pkg::crs_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output crs_pkg::crs_job_type head,
   output logic                 empty
);
   import crs_pkg::*;

   crs_job_type       slots_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   fill_ff, fill_in;

   always_comb begin
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = pop  ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) slots_ff[wr_ff] <= push_job;
   end

   assign head  = slots_ff[rd_ff];
   assign empty = (fill_ff == '0);
   assign full  = (fill_ff == (QPTR_W+1)'(QDEPTH));

endmodule

// File: src/crs_back.sv
// Back end: point table, four neighbor reads, Horner evaluation per axis
// and the result register. Depends on crs_pkg.
module crs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  crs_pkg::crs_job_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,
   output logic                 rsp_tuser
);
   import crs_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_RD   = 3'd1;
   localparam logic [2:0] B_COEF = 3'd2;
   localparam logic [2:0] B_MUL  = 3'd3;
   localparam logic [2:0] B_ADD  = 3'd4;
   localparam logic [2:0] B_OUT  = 3'd5;

   logic [POS_W-1:0]     mem [MAX_POINTS];
   logic [POS_W-1:0]     rdata_ff;
   logic [POS_W-1:0]     p_ff [4];
   logic [2:0]           state_ff;
   logic [2:0]           cnt_ff;
   logic [1:0]           stp_ff;
   crs_job_type          job_ff;
   logic signed [H_W-1:0] a_ff [3], b_ff [3], c_ff [3], h_ff [3];
   logic signed [P_W-1:0] prod_ff [3];
   logic                 out_valid_ff;
   logic [POS_W-1:0]     out_data_ff;
   logic                 out_bad_ff;

   logic                 wr_en, out_free;
   logic [IDX_W-1:0]     rd_addr;
   logic [1:0]           p_sel;
   logic [POS_W-1:0]     sat_pos;

   assign out_free = !out_valid_ff || rsp_tready;
   assign pop      = (state_ff == B_IDLE) && !empty;
   assign wr_en    = pop && head.is_write;
   assign rd_addr  = job_ff.idx[cnt_ff[1:0]];
   assign p_sel    = 2'(cnt_ff - 3'd1);

   always_ff @(posedge clock) begin
      if (wr_en) mem[head.idx[0]] <= head.pos;
      rdata_ff <= mem[rd_addr];
   end

   // round, halve and saturate each axis
   always_comb begin
      logic signed [H_W-1:0] v;
      sat_pos = '0;
      for (int k = 0; k < 3; k++) begin
         v = (h_ff[k] + H_W'(1)) >>> 1;
         if (v > H_W'(64'sh7FFF_FFFF))
            sat_pos[k*COORD_W +: COORD_W] = 32'h7FFF_FFFF;
         else if (v < -H_W'(64'sh8000_0000))
            sat_pos[k*COORD_W +: COORD_W] = 32'h8000_0000;
         else
            sat_pos[k*COORD_W +: COORD_W] = v[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [H_W-1:0] p0, p1, p2, p3, addend;
      logic signed [P_W-1:0] rnd;
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         stp_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (pop && !head.is_write) begin
                  cnt_ff   <= '0;
                  state_ff <= head.bad ? B_OUT : B_RD;
               end
            end
            B_RD: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd4) state_ff <= job_ff.endpt ? B_OUT : B_COEF;
            end
            B_COEF: begin
               stp_ff   <= '0;
               state_ff <= B_MUL;
            end
            B_MUL: state_ff <= B_ADD;
            B_ADD: begin
               stp_ff   <= stp_ff + 2'd1;
               state_ff <= (stp_ff == 2'd2) ? B_OUT : B_MUL;
            end
            B_OUT: begin
               if (out_free) state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
         if (state_ff == B_OUT && out_free) out_valid_ff <= 1'b1;
         else if (rsp_tready)               out_valid_ff <= 1'b0;
      end

      if (pop) job_ff <= head;
      if (state_ff == B_RD && cnt_ff != 3'd0) p_ff[p_sel] <= rdata_ff;

      for (int k = 0; k < 3; k++) begin
         p0 = H_W'($signed(p_ff[0][k*COORD_W +: COORD_W]));
         p1 = H_W'($signed(p_ff[1][k*COORD_W +: COORD_W]));
         p2 = H_W'($signed(p_ff[2][k*COORD_W +: COORD_W]));
         p3 = H_W'($signed(p_ff[3][k*COORD_W +: COORD_W]));
         if (state_ff == B_COEF) begin
            a_ff[k] <= p1 <<< 1;
            b_ff[k] <= p2 - p0;
            c_ff[k] <= (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
            h_ff[k] <= -p0 + ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2) + p3;
         end
         if (state_ff == B_MUL)
            prod_ff[k] <= P_W'(h_ff[k]) * $signed(P_W'({1'b0, job_ff.t}));
         if (state_ff == B_ADD) begin
            case (stp_ff)
               2'd0:    addend = c_ff[k];
               2'd1:    addend = b_ff[k];
               default: addend = a_ff[k];
            endcase
            rnd = (prod_ff[k] + P_W'(32768)) >>> T_W;
            h_ff[k] <= addend + rnd[H_W-1:0];
         end
      end

      if (state_ff == B_OUT && out_free) begin
         out_bad_ff  <= job_ff.bad;
         out_data_ff <= job_ff.bad ? '0 : (job_ff.endpt ? p_ff[1] : sat_pos);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_bad_ff;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for catmull_rom_spline_sampler: random point writes and
// curve evaluations under several register settings, checked against a local predictor.
// Depends on crs_pkg and the sampler RTL only.
module tb_top;
   import crs_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;   // unused register index
   localparam logic       KIND_WRITE = 1'b0;
   localparam logic       KIND_EVAL  = 1'b1;

   typedef struct {
      logic        kind;
      logic [7:0]  slot;
      logic [6:0]  sample;
      logic [31:0] px, py, pz;
   } spline_req_type;

   typedef struct {
      logic [31:0] cx, cy, cz;
      logic        bad;
   } curve_pt_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;   // slot, sample_number, pos_x, pos_y, pos_z
   logic         req_tuser = 1'b0; // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;        // curve_x, curve_y, curve_z
   logic         rsp_tuser;        // bad_request
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [8:0]   csr_wdata = '0;

   // transaction queues and predictor state
   spline_req_type pending_reqs[$];
   curve_pt_type   expected_pts[$];
   logic [31:0]  tbl_x[MAX_POINTS], tbl_y[MAX_POINTS], tbl_z[MAX_POINTS];
   bit           gen_written[MAX_POINTS];
   logic         cfg_closed;
   logic [7:0]   cfg_sps;
   logic [8:0]   cfg_count;
   int           mismatch_count = 0;
   int           send_gap = 0;
   int           recv_gap = 0;
   int           hold_cnt = 0;
   bit           stall_request = 0;
   bit           stall_done = 0;

   catmull_rom_spline_sampler u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int eff_count();
      if (cfg_count < 2) return 2;
      if (cfg_count > MAX_POINTS) return MAX_POINTS;
      return cfg_count;
   endfunction

   function automatic int eff_sps();
      if (cfg_sps < 1) return 1;
      if (cfg_sps > 128) return 128;
      return cfg_sps;
   endfunction

   // wrap on a closed curve, clamp on an open one
   function automatic int neighbor_idx(int idx);
      int n;
      n = eff_count();
      if (cfg_closed) begin
         idx = idx % n;
         if (idx < 0) idx += n;
         return idx;
      end
      if (idx < 0) return 0;
      if (idx > n - 1) return n - 1;
      return idx;
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // Horner evaluation of one axis with rounding after each multiply
   function automatic logic [31:0] eval_axis(logic [31:0] q0, q1, q2, q3, longint tq);
      longint p0, p1, p2, p3, ca, cb, cc, h;
      p0 = longint'(signed'(q0));
      p1 = longint'(signed'(q1));
      p2 = longint'(signed'(q2));
      p3 = longint'(signed'(q3));
      ca = 2 * p1;
      cb = p2 - p0;
      cc = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      h  = -p0 + 3 * p1 - 3 * p2 + p3;
      h  = cc + ((h * tq + 32768) >>> 16);
      h  = cb + ((h * tq + 32768) >>> 16);
      h  = ca + ((h * tq + 32768) >>> 16);
      return sat32((h + 1) >>> 1);
   endfunction

   function automatic bit is_open_end(spline_req_type r);
      return !cfg_closed && r.slot == eff_count() - 1 && r.sample == 0;
   endfunction

   function automatic bit is_bad(spline_req_type r);
      int segs;
      segs = cfg_closed ? eff_count() : eff_count() - 1;
      return !is_open_end(r) && (r.slot >= segs || r.sample >= eff_sps());
   endfunction

   // apply an accepted write to the point table, or queue the expected result of an evaluation
   task automatic predict_curve(spline_req_type r);
      curve_pt_type pt;
      int        i0, i1, i2, i3, lastp;
      longint    tq;
      if (r.kind == KIND_WRITE) begin
         tbl_x[r.slot] = r.px;
         tbl_y[r.slot] = r.py;
         tbl_z[r.slot] = r.pz;
         return;
      end
      pt = '{32'd0, 32'd0, 32'd0, 1'b0};
      if (is_open_end(r)) begin
         lastp = eff_count() - 1;
         pt.cx = tbl_x[lastp];
         pt.cy = tbl_y[lastp];
         pt.cz = tbl_z[lastp];
      end else if (is_bad(r)) begin
         pt.bad = 1'b1;
      end else begin
         tq = (longint'(r.sample) << 16) / eff_sps();
         i0 = neighbor_idx(int'(r.slot) - 1);
         i1 = neighbor_idx(int'(r.slot));
         i2 = neighbor_idx(int'(r.slot) + 1);
         i3 = neighbor_idx(int'(r.slot) + 2);
         pt.cx = eval_axis(tbl_x[i0], tbl_x[i1], tbl_x[i2], tbl_x[i3], tq);
         pt.cy = eval_axis(tbl_y[i0], tbl_y[i1], tbl_y[i2], tbl_y[i3], tq);
         pt.cz = eval_axis(tbl_z[i0], tbl_z[i1], tbl_z[i2], tbl_z[i3], tq);
      end
      expected_pts.insert(expected_pts.size(), pt);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: hold the item until accepted, then advance or idle
   always @(posedge clock) begin
      spline_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            r.kind   = req_tuser;
            r.slot   = req_tdata[7:0];
            r.sample = req_tdata[14:8];
            r.px     = req_tdata[46:15];
            r.py     = req_tdata[78:47];
            r.pz     = req_tdata[110:79];
            predict_curve(r);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               r = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= r.kind;
               req_tdata  <= {1'b0, r.pz, r.py, r.px, r.sample, r.slot};
               send_gap   <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, including one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_request && !stall_done) begin
         stall_done <= 1;
         hold_cnt   <= 600;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt   <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap   <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         recv_gap   <= pick_gap();
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      curve_pt_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h bad=%b", rsp_tdata, rsp_tuser);
         end else begin
            e = expected_pts.pop_front();
            if (rsp_tdata[31:0] !== e.cx || rsp_tdata[63:32] !== e.cy ||
                rsp_tdata[95:64] !== e.cz || rsp_tuser !== e.bad) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp x=%h y=%h z=%h bad=%b got x=%h y=%h z=%h bad=%b",
                           e.cx, e.cy, e.cz, e.bad, rsp_tdata[31:0], rsp_tdata[63:32],
                           rsp_tdata[95:64], rsp_tuser);
            end
         end
      end
   end

   task automatic csr_write(logic [1:0] addr, logic [8:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_CLOSED: cfg_closed = data[0];
         CSR_SPS:    cfg_sps    = data[7:0];
         CSR_COUNT:  cfg_count  = data;
         default: ;
      endcase
   endtask

   // drain everything, then let a trailing write retire
   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && expected_pts.size() == 0);
      @(posedge clock);
      wait (!req_tvalid && expected_pts.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2, 3, 4, 5: return $urandom_range(0, 200 << 16) - (100 << 16);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_write(int slot, logic [31:0] x, y, z);
      spline_req_type r;
      r = '{KIND_WRITE, slot[7:0], 7'($urandom), x, y, z};
      gen_written[slot] = 1;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic push_eval(int slot, int sample);
      spline_req_type r;
      r = '{KIND_EVAL, slot[7:0], sample[6:0], $urandom, $urandom, $urandom};
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // write a random slot or evaluate a random segment; replace the evaluation by a write if it would read a fresh entry
   task automatic push_random_item();
      spline_req_type r;
      int          ids[4];
      int          miss;
      int          segs;
      segs = cfg_closed ? eff_count() : eff_count() - 1;
      if ($urandom_range(0, 99) < 35) begin
         push_write($urandom_range(0, 255), rand_coord(), rand_coord(), rand_coord());
         return;
      end
      r.kind   = KIND_EVAL;
      r.slot   = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, segs - 1))
                                            : 8'($urandom_range(0, 255));
      r.sample = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, eff_sps() - 1))
                                            : 7'($urandom_range(0, 127));
      if ($urandom_range(0, 19) == 0) begin
         r.slot   = 8'(eff_count() - 1);
         r.sample = 7'd0;
      end
      miss = -1;
      if (is_open_end(r)) begin
         if (!gen_written[eff_count() - 1]) miss = eff_count() - 1;
      end else if (!is_bad(r)) begin
         ids[0] = neighbor_idx(int'(r.slot) - 1);
         ids[1] = neighbor_idx(int'(r.slot));
         ids[2] = neighbor_idx(int'(r.slot) + 1);
         ids[3] = neighbor_idx(int'(r.slot) + 2);
         foreach (ids[k])
            if (miss < 0 && !gen_written[ids[k]]) miss = ids[k];
      end
      if (miss >= 0) push_write(miss, rand_coord(), rand_coord(), rand_coord());
      else push_eval(int'(r.slot), int'(r.sample));
   endtask

   initial begin
      int phase_closed[8];
      int phase_sps[8];
      int phase_count[8];
      phase_closed = '{1, 0, 1, 0, 1, 0, 1, 0};
      phase_sps    = '{1, 128, 128, 0, 255, 200, 5, 3};
      phase_count  = '{2, 256, 256, 0, 511, 3, 300, 17};
      cfg_closed = 1'b0;
      cfg_sps    = 8'd8;
      cfg_count  = 9'd4;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes on the reset settings (open, 8 samples, 4 points)
      push_write(0, 32'h7fffffff, 32'h80000000, 32'h00000000);
      push_write(1, 32'h80000000, 32'h7fffffff, 32'h00010000);
      push_write(2, 32'h7fffffff, 32'h80000000, 32'hffff0000);
      push_write(3, 32'h80000000, 32'h7fffffff, 32'h12345678);
      push_eval(0, 0);
      push_eval(0, 4);
      push_eval(1, 3);
      push_eval(2, 7);
      push_eval(3, 0);     // open end returns the last point
      push_eval(3, 1);     // past the last segment
      push_eval(0, 8);     // sample out of range
      push_eval(0, 127);
      push_eval(255, 0);
      push_write(200, 32'h00020000, 32'hfffe0000, 32'h00030000);  // beyond count
      push_write(255, rand_coord(), rand_coord(), rand_coord());
      push_eval(1, 5);
      wait_idle();
      csr_write(CSR_SPARE, 9'h1ff);   // ignored index

      foreach (phase_sps[p]) begin
         csr_write(CSR_CLOSED, 9'(phase_closed[p]));
         csr_write(CSR_SPS, 9'(phase_sps[p]));
         csr_write(CSR_COUNT, 9'(phase_count[p]));
         for (int n = 0; n < 175; n++) push_random_item();
         if (p == 2) stall_request = 1;   // fill the pipe against a long hold-off
         wait_idle();
      end

      wait_idle();
      if (mismatch_count == 0 && expected_pts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
src/crs_pkg.sv
src/crs_front.sv
src/crs_queue.sv
src/crs_back.sv
src/catmull_rom_spline_sampler.sv
dv/tb_top.sv
